[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the frame deframer.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/wsfd_pkg.sv]
// Types, constants and helpers for the frame deframer.
// No dependencies.
package wsfd_pkg;

  localparam int unsigned CountWidth = 33;
  localparam logic [31:0] MaxFrameBytesReset = 32'd65536;

  typedef enum logic [2:0] {
    PH_BYTE0,
    PH_BYTE1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    LEN_7BIT,
    LEN_16BIT,
    LEN_64BIT
  } len_form_e;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;
  localparam logic [3:0] ExtEnd16 = 4'd4;
  localparam logic [3:0] ExtEnd64 = 4'd10;
  localparam logic [3:0] HdrBytes7 = 4'd6;
  localparam logic [3:0] HdrBytes16 = 4'd8;
  localparam logic [3:0] HdrBytes64 = 4'd14;

  function automatic logic [3:0] hdr_bytes(input len_form_e form);
    logic [3:0] res;
    res = HdrBytes7;
    unique case (form)
      LEN_7BIT:  res = HdrBytes7;
      LEN_16BIT: res = HdrBytes16;
      LEN_64BIT: res = HdrBytes64;
      default:   res = HdrBytes7;
    endcase
    return res;
  endfunction

endpackage

[rtl/websocket_frame_deframer.sv]
// Frame deframer top level: header parse, length decode, payload unmask.
// Depends on wsfd_pkg and assert_macros.svh.
//
//   channel | direction | handshake                  | payload
//   in      | sink      | in_valid_i / in_ready_o    | data_byte_i
//   out     | source    | out_valid_o / out_ready_i  | kind, fin, opcode, length, hdr, data, last
//   cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_data_i (max_frame_bytes)
//
// One byte per cycle; a result is registered and appears in the cycle after its byte is taken.
// The result register sets the rate: a byte is taken while it is empty or being drained.
// Reset clears the parse state and sets max_frame_bytes to 65536.
// After a size error every byte is taken and dropped until reset.
`include "assert_macros.svh"

module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic        fin_o,
  output logic [3:0]  opcode_o,
  output logic [63:0] payload_length_o,
  output logic [3:0]  header_bytes_o,
  output logic [7:0]  data_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned CW = wsfd_pkg::CountWidth;

  wsfd_pkg::phase_e    phase_q, phase_d;
  wsfd_pkg::len_form_e len_form_q, len_form_d;
  logic [3:0]          header_index_q, header_index_d;
  logic [63:0]         length_accum_q, length_accum_d;
  logic [31:0]         mask_key_q, mask_key_d;
  logic [63:0]         payload_remaining_q, payload_remaining_d;
  logic [1:0]          key_position_q, key_position_d;
  logic [CW-1:0]       frame_count_q, frame_count_d;
  logic                fin_flag_q, fin_flag_d;
  logic [3:0]          message_opcode_q, message_opcode_d;
  logic                at_msg_start_q, at_msg_start_d;
  logic                error_halt_q, error_halt_d;
  logic [31:0]         max_frame_q;

  logic                out_valid_q, out_valid_d;
  wsfd_pkg::kind_e     res_kind_q, res_kind_d;
  logic                res_fin_q, res_fin_d;
  logic [3:0]          res_opcode_q, res_opcode_d;
  logic [63:0]         res_length_q, res_length_d;
  logic [3:0]          res_hdr_q, res_hdr_d;
  logic [7:0]          res_data_q, res_data_d;
  logic                res_last_q, res_last_d;

  logic                in_take;
  logic                emit;
  logic [CW-1:0]       count_inc;
  logic                over_limit;
  logic [3:0]          idx_inc;
  logic [63:0]         remaining_dec;
  logic [7:0]          key_byte;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign count_inc     = (phase_q == wsfd_pkg::PH_BYTE0) ? CW'(1) : frame_count_q + CW'(1);
  assign over_limit    = count_inc > {1'b0, max_frame_q};
  assign idx_inc       = header_index_q + 4'd1;
  assign remaining_dec = payload_remaining_q - 64'd1;

  always_comb begin
    case (key_position_q)
      2'd0:    key_byte = mask_key_q[31:24];
      2'd1:    key_byte = mask_key_q[23:16];
      2'd2:    key_byte = mask_key_q[15:8];
      default: key_byte = mask_key_q[7:0];
    endcase
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (in_take && !error_halt_q && !over_limit) begin
      unique case (phase_q)
        wsfd_pkg::PH_BYTE0: phase_d = wsfd_pkg::PH_BYTE1;
        wsfd_pkg::PH_BYTE1: begin
          if (data_byte_i[6:0] < wsfd_pkg::LenCode16) begin
            phase_d = wsfd_pkg::PH_MASK;
          end else begin
            phase_d = wsfd_pkg::PH_EXTLEN;
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          if ((len_form_q == wsfd_pkg::LEN_16BIT && idx_inc >= wsfd_pkg::ExtEnd16) ||
              (len_form_q != wsfd_pkg::LEN_16BIT && idx_inc >= wsfd_pkg::ExtEnd64)) begin
            phase_d = wsfd_pkg::PH_MASK;
          end
        end
        wsfd_pkg::PH_MASK: begin
          if (idx_inc >= wsfd_pkg::hdr_bytes(len_form_q)) begin
            phase_d = (length_accum_q == 64'd0) ? wsfd_pkg::PH_BYTE0 : wsfd_pkg::PH_PAYLOAD;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          if (remaining_dec == 64'd0) begin
            phase_d = wsfd_pkg::PH_BYTE0;
          end
        end
        default: phase_d = wsfd_pkg::PH_BYTE0;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    len_form_d          = len_form_q;
    header_index_d      = header_index_q;
    length_accum_d      = length_accum_q;
    mask_key_d          = mask_key_q;
    payload_remaining_d = payload_remaining_q;
    key_position_d      = key_position_q;
    frame_count_d       = frame_count_q;
    fin_flag_d          = fin_flag_q;
    message_opcode_d    = message_opcode_q;
    at_msg_start_d      = at_msg_start_q;
    error_halt_d        = error_halt_q;
    emit                = 1'b0;
    res_kind_d          = wsfd_pkg::KIND_HEADER;
    res_fin_d           = fin_flag_q;
    res_opcode_d        = message_opcode_q;
    res_length_d        = length_accum_q;
    res_hdr_d           = wsfd_pkg::hdr_bytes(len_form_q);
    res_data_d          = 8'd0;
    res_last_d          = 1'b0;

    if (in_take && !error_halt_q) begin
      if (over_limit) begin
        error_halt_d = 1'b1;
        emit         = 1'b1;
        res_kind_d   = wsfd_pkg::KIND_ERROR;
        res_fin_d    = 1'b0;
        res_opcode_d = 4'd0;
        res_length_d = 64'd0;
        res_hdr_d    = 4'd0;
        res_last_d   = 1'b1;
      end else begin
        frame_count_d = count_inc;
        unique case (phase_q)
          wsfd_pkg::PH_BYTE0: begin
            fin_flag_d = data_byte_i[7];
            if (at_msg_start_q) begin
              message_opcode_d = data_byte_i[3:0];
            end
            at_msg_start_d      = data_byte_i[7];
            header_index_d      = 4'd1;
            len_form_d          = wsfd_pkg::LEN_7BIT;
            length_accum_d      = 64'd0;
            mask_key_d          = 32'd0;
            key_position_d      = 2'd0;
            payload_remaining_d = 64'd0;
          end
          wsfd_pkg::PH_BYTE1: begin
            header_index_d = 4'd2;
            if (data_byte_i[6:0] == wsfd_pkg::LenCode16) begin
              len_form_d     = wsfd_pkg::LEN_16BIT;
              length_accum_d = 64'd0;
            end else if (data_byte_i[6:0] == wsfd_pkg::LenCode64) begin
              len_form_d     = wsfd_pkg::LEN_64BIT;
              length_accum_d = 64'd0;
            end else begin
              len_form_d     = wsfd_pkg::LEN_7BIT;
              length_accum_d = {57'd0, data_byte_i[6:0]};
            end
          end
          wsfd_pkg::PH_EXTLEN: begin
            length_accum_d = {length_accum_q[55:0], data_byte_i};
            header_index_d = idx_inc;
          end
          wsfd_pkg::PH_MASK: begin
            mask_key_d     = {mask_key_q[23:0], data_byte_i};
            header_index_d = idx_inc;
            if (idx_inc >= wsfd_pkg::hdr_bytes(len_form_q)) begin
              payload_remaining_d = length_accum_q;
              key_position_d      = 2'd0;
              emit                = 1'b1;
              res_last_d          = (length_accum_q == 64'd0);
            end
          end
          wsfd_pkg::PH_PAYLOAD: begin
            key_position_d      = key_position_q + 2'd1;
            payload_remaining_d = remaining_dec;
            emit                = 1'b1;
            res_kind_d          = wsfd_pkg::KIND_PAYLOAD;
            res_data_d          = data_byte_i ^ key_byte;
            res_last_d          = (remaining_dec == 64'd0);
          end
          default: ;
        endcase
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q             <= wsfd_pkg::PH_BYTE0;
      len_form_q          <= wsfd_pkg::LEN_7BIT;
      header_index_q      <= 4'd0;
      length_accum_q      <= 64'd0;
      mask_key_q          <= 32'd0;
      payload_remaining_q <= 64'd0;
      key_position_q      <= 2'd0;
      frame_count_q       <= '0;
      fin_flag_q          <= 1'b0;
      message_opcode_q    <= 4'd0;
      at_msg_start_q      <= 1'b1;
      error_halt_q        <= 1'b0;
      max_frame_q         <= wsfd_pkg::MaxFrameBytesReset;
      out_valid_q         <= 1'b0;
    end else begin
      phase_q             <= phase_d;
      len_form_q          <= len_form_d;
      header_index_q      <= header_index_d;
      length_accum_q      <= length_accum_d;
      mask_key_q          <= mask_key_d;
      payload_remaining_q <= payload_remaining_d;
      key_position_q      <= key_position_d;
      frame_count_q       <= frame_count_d;
      fin_flag_q          <= fin_flag_d;
      message_opcode_q    <= message_opcode_d;
      at_msg_start_q      <= at_msg_start_d;
      error_halt_q        <= error_halt_d;
      out_valid_q         <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_frame_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_kind_q   <= res_kind_d;
      res_fin_q    <= res_fin_d;
      res_opcode_q <= res_opcode_d;
      res_length_q <= res_length_d;
      res_hdr_q    <= res_hdr_d;
      res_data_q   <= res_data_d;
      res_last_q   <= res_last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = res_kind_q;
  assign fin_o            = res_fin_q;
  assign opcode_o         = res_opcode_q;
  assign payload_length_o = res_length_q;
  assign header_bytes_o   = res_hdr_q;
  assign data_o           = res_data_q;
  assign last_o           = res_last_q;

  `ASSERT_SAME(a_error_is_last, out_valid_q && res_kind_q == wsfd_pkg::KIND_ERROR, res_last_q)
  `ASSERT_NEXT(a_halt_is_silent, error_halt_q && (!out_valid_q || out_ready_i), !out_valid_q)
  `ASSERT_SAME(a_payload_nonzero, phase_q == wsfd_pkg::PH_PAYLOAD, payload_remaining_q != 64'd0)
  `ASSERT_NEXT(a_error_halts, in_take && !error_halt_q && over_limit, error_halt_q)

endmodule
